FILE: hdl/irdc_pkg.sv
// shared types, constants and helpers for the integer to radix digit converter
package irdc_pkg;

  localparam int MAX_RADIX_DEF  = 32;
  localparam int MAX_DIGITS_DEF = 32;

  localparam int RADIX_W  = 6;
  localparam int ALPHA_N  = 32;
  localparam int ALPHA_W  = ALPHA_N * 8;
  localparam int AIDX_W   = 5;
  localparam int CFG_W    = 64;
  localparam int CIDX_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int MAG_W    = VALUE_W + 1;

  // divider: dividend padded so that a whole number of 8-bit groups fits
  localparam int DIV_STEPS = 8;
  localparam int DIV_CYC   = 5;
  localparam int QUO_W     = DIV_STEPS * DIV_CYC;
  localparam int DCNT_W    = 3;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  localparam logic [7:0] MINUS_CHAR = 8'h2D;

  localparam logic [CIDX_W-1:0] REG_RADIX   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_ALPHA_0 = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ALPHA_1 = 3'd2;
  localparam logic [CIDX_W-1:0] REG_ALPHA_2 = 3'd3;
  localparam logic [CIDX_W-1:0] REG_ALPHA_3 = 3'd4;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [ALPHA_W-1:0] alphabet;
  } cfg_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } item_t;

  function automatic logic [7:0] alpha_byte(input logic [ALPHA_W-1:0] alphabet,
                                            input logic [AIDX_W-1:0] idx);
    return alphabet[{idx, 3'b000} +: 8];
  endfunction

endpackage

FILE: hdl/integer_to_custom_radix_digits_core.sv
// top level of the integer to custom radix digit converter
// Usage:
//   configuration: cfg_we writes cfg_data to register cfg_index (0 radix,
//   1..4 alphabet bytes 0-7, 8-15, 16-23, 24-31); other indices are ignored.
//   every write starts an alphabet duplicate sweep during which full
//   stays high; reset starts the same sweep with all registers cleared.
//   input: in_value is taken when push is high and full is low. with a bad
//   radix (below 2, above MAX_RADIX, or repeated digit bytes) it yields nothing.
//   results: while empty is low, out_character/out_last hold the oldest
//   character, taken when pop is high; out_last marks an item's final digit.
// Timing: the divider takes 8 quotient bits per cycle over a 40-bit dividend,
//   one division pass per digit; the characters are sent only after the last
//   digit has been divided; items convert one at a time in the back end.
//   a two-entry queue holds items while the divider is busy, and a stalled
//   receiver holds the output register, halting emission without loss.
module integer_to_custom_radix_digits_core import irdc_pkg::*; #(
  parameter int MAX_RADIX  = MAX_RADIX_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [VALUE_W-1:0] in_value,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_character,
  output logic               out_last
);

  cfg_t  cfg;
  item_t q_item;
  item_t q_head;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_nempty;

  irdc_front #(
    .MAX_RADIX(MAX_RADIX)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_value (in_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item),
    .cfg      (cfg)
  );

  irdc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_item  (q_item),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_nempty(q_nempty),
    .q_head  (q_head)
  );

  irdc_back #(
    .MAX_RADIX (MAX_RADIX),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .q_nempty     (q_nempty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_character(out_character),
    .out_last     (out_last)
  );

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_nempty)
    else $error("back end took an item from an empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("item written into a full queue");

  a_sweep_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> full)
    else $error("input open before the alphabet sweep finished");

  a_sweep_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_we) |-> full)
    else $error("input open right after a configuration write");
`endif

endmodule

FILE: hdl/irdc_front.sv
// configuration registers, alphabet duplicate sweep and input item intake
module irdc_front import irdc_pkg::*; #(
  parameter int MAX_RADIX = MAX_RADIX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               q_full,
  output logic               q_push,
  output item_t              q_item,
  output cfg_t               cfg
);

  logic [RADIX_W-1:0] radix_r;
  logic [CFG_W-1:0]   alpha_r [4];
  logic               chk_busy_r;
  logic [AIDX_W-1:0]  chk_idx_r;
  logic               dup_r;
  logic [ALPHA_W-1:0] alphabet;
  logic [7:0]         sel_byte;
  logic               dup_hit;
  logic               radix_ok;
  logic [MAG_W-1:0]   ext;

  assign alphabet = {alpha_r[3], alpha_r[2], alpha_r[1], alpha_r[0]};
  assign cfg.radix    = radix_r;
  assign cfg.alphabet = alphabet;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= '0;
      alpha_r[0] <= '0;
      alpha_r[1] <= '0;
      alpha_r[2] <= '0;
      alpha_r[3] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX:   radix_r    <= cfg_data[RADIX_W-1:0];
        REG_ALPHA_0: alpha_r[0] <= cfg_data;
        REG_ALPHA_1: alpha_r[1] <= cfg_data;
        REG_ALPHA_2: alpha_r[2] <= cfg_data;
        REG_ALPHA_3: alpha_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // each sweep cycle compares one alphabet byte against every lower byte
  assign sel_byte = alpha_byte(alphabet, chk_idx_r);

  always_comb begin
    dup_hit = 1'b0;
    for (int j = 0; j < ALPHA_N; j++) begin
      if ((AIDX_W'(j) < chk_idx_r) && ({1'b0, chk_idx_r} < radix_r) &&
          (alpha_byte(alphabet, AIDX_W'(j)) == sel_byte)) begin
        dup_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_busy_r <= 1'b1;
      chk_idx_r  <= '0;
      dup_r      <= 1'b0;
    end else if (cfg_we) begin
      chk_busy_r <= 1'b1;
      chk_idx_r  <= '0;
      dup_r      <= 1'b0;
    end else if (chk_busy_r) begin
      dup_r     <= dup_r | dup_hit;
      chk_idx_r <= chk_idx_r + 1'b1;
      if (chk_idx_r == AIDX_W'(ALPHA_N - 1)) begin
        chk_busy_r <= 1'b0;
      end
    end
  end

  assign radix_ok = (radix_r >= RADIX_W'(2)) && (radix_r <= RADIX_W'(MAX_RADIX)) && !dup_r;

  assign full = chk_busy_r || q_full;

  // items taken under a bad radix produce nothing and are dropped here
  assign q_push = push && !full && radix_ok;

  assign ext        = {in_value[VALUE_W-1], in_value};
  assign q_item.neg = in_value[VALUE_W-1];
  assign q_item.mag = in_value[VALUE_W-1] ? (~ext + 1'b1) : ext;

endmodule

FILE: hdl/irdc_queue.sv
// short item queue between intake and conversion
module irdc_queue import irdc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_push,
  input  item_t q_item,
  output logic  q_full,
  input  logic  q_pop,
  output logic  q_nempty,
  output item_t q_head
);

  item_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_CW-1:0]  cnt_r;

  assign q_full   = (cnt_r == Q_CW'(Q_DEPTH));
  assign q_nempty = (cnt_r != '0);
  assign q_head   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      priority if (q_push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (q_pop && !q_push) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        cnt_r <= cnt_r;
      end
    end
  end

endmodule

FILE: hdl/irdc_back.sv
// iterative radix divider, digit stack and character output register
module irdc_back import irdc_pkg::*; #(
  parameter int MAX_RADIX  = MAX_RADIX_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_nempty,
  input  item_t      q_head,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_character,
  output logic       out_last
);

  localparam int DIG_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int SA_W  = $clog2(MAX_DIGITS);
  localparam int SP_W  = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SIGN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state_r;
  logic              neg_r;
  logic [QUO_W-1:0]  quo_r;
  logic [DIG_W-1:0]  rem_r;
  logic [DCNT_W-1:0] step_r;
  logic [SP_W-1:0]   sp_r;
  logic [DIG_W-1:0]  stack_r [MAX_DIGITS];
  logic [QUO_W-1:0]  quo_nxt;
  logic [DIG_W-1:0]  rem_nxt;
  logic [RADIX_W-1:0] trial;
  logic              out_valid_r;
  logic [7:0]        out_char_r;
  logic              out_last_r;
  logic              can_emit;
  logic [SP_W-1:0]   sp_m1;

  // eight restoring steps per cycle, remainder always below the radix
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial   = RADIX_W'({rem_nxt, quo_nxt[QUO_W-1]});
      quo_nxt = {quo_nxt[QUO_W-2:0], 1'b0};
      if (trial >= cfg.radix) begin
        trial      = trial - cfg.radix;
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DIG_W-1:0];
    end
  end

  assign sp_m1     = sp_r - 1'b1;
  assign can_emit  = !out_valid_r || pop;
  assign q_pop     = (state_r == S_IDLE) && q_nempty;

  always_ff @(posedge clk) begin
    if (state_r == S_DIV && step_r == DCNT_W'(DIV_CYC - 1)) begin
      stack_r[sp_r[SA_W-1:0]] <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      sp_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_nempty) begin
            neg_r   <= q_head.neg;
            quo_r   <= QUO_W'(q_head.mag);
            rem_r   <= '0;
            step_r  <= '0;
            sp_r    <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          quo_r <= quo_nxt;
          if (step_r == DCNT_W'(DIV_CYC - 1)) begin
            sp_r   <= sp_r + 1'b1;
            rem_r  <= '0;
            step_r <= '0;
            // quotient zero: digits complete, zero itself still gave one digit
            if (quo_nxt == '0) begin
              state_r <= neg_r ? S_SIGN : S_EMIT;
            end
          end else begin
            rem_r  <= rem_nxt;
            step_r <= step_r + 1'b1;
          end
        end
        S_SIGN: begin
          if (can_emit) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (can_emit) begin
            sp_r <= sp_m1;
            if (sp_r == SP_W'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      priority if (state_r == S_SIGN && can_emit) begin
        out_valid_r <= 1'b1;
        out_char_r  <= MINUS_CHAR;
        out_last_r  <= 1'b0;
      end else if (state_r == S_EMIT && can_emit) begin
        out_valid_r <= 1'b1;
        out_char_r  <= alpha_byte(cfg.alphabet, AIDX_W'(stack_r[sp_m1[SA_W-1:0]]));
        out_last_r  <= (sp_r == SP_W'(1));
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
    end
  end

  assign empty         = !out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

FILE: test/integer_to_custom_radix_digits_core_tb.sv
`timescale 1ns / 100ps
// testbench for the integer to custom radix digit converter: directed and random requests
module integer_to_custom_radix_digits_core_tb import irdc_pkg::*;;

  localparam int ITEM_TARGET     = 470;
  localparam int DRAIN_CYCLES    = 700;
  localparam int STALL_LIMIT     = 5000;
  localparam int LONG_HOLD       = 400;
  localparam int LONG_HOLD_EVERY = 5000;
  localparam int MIN_RADIX       = 2;
  localparam logic [CIDX_W-1:0] REG_UNUSED = REG_ALPHA_3 + 3'd1;

  typedef struct {
    logic [7:0] character;
    logic       last;
  } emitted_char_t;

  class digit_scoreboard;
    logic [RADIX_W-1:0] radix;
    logic [CFG_W-1:0]   alpha_words [4];
    emitted_char_t      pending_chars [$];
    int unsigned        failures;

    function new();
      radix = '0;
      foreach (alpha_words[i]) alpha_words[i] = '0;
      failures = 0;
    endfunction

    function void set_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      case (idx)
        REG_RADIX:   radix = data[RADIX_W-1:0];
        REG_ALPHA_0: alpha_words[0] = data;
        REG_ALPHA_1: alpha_words[1] = data;
        REG_ALPHA_2: alpha_words[2] = data;
        REG_ALPHA_3: alpha_words[3] = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] digit_char(input int unsigned d);
      return alpha_words[d / 8][(d % 8) * 8 +: 8];
    endfunction

    function bit base_usable();
      int unsigned r;
      r = radix;
      if (r < MIN_RADIX || r > MAX_RADIX_DEF) return 1'b0;
      for (int i = 0; i < r; i++)
        for (int j = i + 1; j < r; j++)
          if (digit_char(i) == digit_char(j)) return 1'b0;
      return 1'b1;
    endfunction

    // works out the characters that one accepted request produces
    function void note_value(input logic [VALUE_W-1:0] v);
      logic [MAG_W-1:0] mag;
      logic [MAG_W-1:0] base;
      int unsigned      digits [$];
      emitted_char_t    c;
      if (!base_usable()) return;
      base = MAG_W'(radix);
      // 33-bit magnitude so the most negative value converts cleanly
      mag = v[VALUE_W-1] ? MAG_W'(0) - {1'b1, v} : {1'b0, v};
      if (mag == 0) digits.push_front(0);
      while (mag != 0) begin
        digits.push_front(int'(mag % base));
        mag = mag / base;
      end
      if (v[VALUE_W-1]) begin
        c.character = MINUS_CHAR;
        c.last      = 1'b0;
        pending_chars.push_back(c);
      end
      foreach (digits[i]) begin
        c.character = digit_char(digits[i]);
        c.last      = (i == digits.size() - 1);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(input logic [7:0] ch, input logic last);
      emitted_char_t want;
      if (pending_chars.size() == 0) begin
        $error("character %02h with no request outstanding", ch);
        failures++;
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.character) begin
        $error("character: expected %02h, got %02h", want.character, ch);
        failures++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        failures++;
      end
    endfunction

    function int pending_count();
      return pending_chars.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               push = 1'b0;
  logic               full;
  logic [VALUE_W-1:0] in_value = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [7:0]         out_character;
  logic               out_last;

  digit_scoreboard sb = new();
  logic [CFG_W-1:0] alphabet_words [4];
  int item_count = 0;

  always #4 clk = ~clk;

  integer_to_custom_radix_digits_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .in_value      (in_value),
    .empty         (empty),
    .pop           (pop),
    .out_character (out_character),
    .out_last      (out_last)
  );

  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_char(out_character, out_last);
  end

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    sb.set_reg(idx, data);
  endtask

  // writes every register in a rotated order from a random start, now and then a stray index too
  task automatic load_config(input logic [RADIX_W-1:0] r);
    logic [CIDX_W-1:0] order [5];
    logic [CFG_W-1:0]  data [5];
    int start;
    order = '{REG_RADIX, REG_ALPHA_0, REG_ALPHA_1, REG_ALPHA_2, REG_ALPHA_3};
    data[0] = {32'($urandom), 26'($urandom), r};
    for (int i = 0; i < 4; i++) data[i + 1] = alphabet_words[i];
    start = $urandom_range(0, 4);
    for (int i = 0; i < 5; i++) write_reg(order[(start + i) % 5], data[(start + i) % 5]);
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_UNUSED + CIDX_W'($urandom_range(0, 2)), {$urandom, $urandom});
  endtask

  task automatic shuffle_alphabet();
    logic [7:0] pool [256];
    logic [7:0] t;
    int j;
    foreach (pool[i]) pool[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    for (int w = 0; w < 4; w++)
      for (int b = 0; b < 8; b++) alphabet_words[w][b * 8 +: 8] = pool[w * 8 + b];
  endtask

  task automatic copy_digit(input int unsigned from_pos, input int unsigned to_pos);
    alphabet_words[to_pos / 8][(to_pos % 8) * 8 +: 8] =
      alphabet_words[from_pos / 8][(from_pos % 8) * 8 +: 8];
  endtask

  task automatic random_setup();
    logic [RADIX_W-1:0] r;
    int unsigned a, b;
    shuffle_alphabet();
    case ($urandom_range(0, 11))
      0: r = RADIX_W'($urandom_range(0, MIN_RADIX - 1));
      1: r = RADIX_W'($urandom_range(MAX_RADIX_DEF + 1, 63));
      2: begin
        r = RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX_DEF));
        a = $urandom_range(0, r - 1);
        b = $urandom_range(0, r - 2);
        if (b >= a) b++;
        copy_digit(a, b);
      end
      3: r = RADIX_W'(MIN_RADIX);
      4: r = RADIX_W'(MAX_RADIX_DEF);
      default: r = RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX_DEF));
    endcase
    load_config(r);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(input int unsigned base);
    logic [63:0] p;
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4: return VALUE_W'($urandom_range(0, 100)) - VALUE_W'(50);
      5: begin
        // around a power of the radix, where the digit count changes
        if (base < MIN_RADIX) base = 10;
        p = 1;
        k = $urandom_range(1, 31);
        while (k > 0 && p * base <= 64'h8000_0000) begin
          p = p * base;
          k--;
        end
        p = p + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 1) ? VALUE_W'(p) : VALUE_W'(-p);
      end
      6: case ($urandom_range(0, 3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
      default: return VALUE_W'($signed($urandom) >>> $urandom_range(0, 31));
    endcase
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 19))
      0: return $urandom_range(20, 100);
      1, 2, 3, 4, 5: return $urandom_range(1, 4);
      default: return 0;
    endcase
  endfunction

  task automatic send(input logic [VALUE_W-1:0] v, input bit gappy);
    int gap;
    gap = gappy ? pick_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push     <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_value(v);
    item_count++;
    @(negedge clk);
  endtask

  // wait for every outstanding character, then let silent requests clear the core
  task automatic settle();
    push <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : receiver
    int cyc, hold, burst;
    cyc   = 0;
    hold  = 0;
    burst = 0;
    forever begin
      @(negedge clk);
      cyc++;
      // long back-pressure so the core fills up and raises full
      if (cyc % LONG_HOLD_EVERY == 0) hold = LONG_HOLD;
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else if (burst > 0) begin
        pop <= 1'b1;
        burst--;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            pop  <= 1'b0;
            hold = $urandom_range(20, 80);
          end
          1: begin
            pop   <= 1'b1;
            burst = $urandom_range(50, 200);
          end
          2, 3, 4, 5: begin
            pop  <= 1'b0;
            hold = $urandom_range(0, 3);
          end
          default: pop <= 1'b1;
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int n;
    bit gappy;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // radix still zero from reset: nothing comes out
    send(32'd42, 1'b0);
    settle();

    alphabet_words = '{64'h3736353433323130, 64'h3030303030303938, '0, '0};
    load_config(RADIX_W'(10));
    write_reg(REG_UNUSED, '1);
    send(32'd0, 1'b0);
    send(32'd1, 1'b0);
    send(32'hFFFF_FFFF, 1'b0);
    send(32'h7FFF_FFFF, 1'b0);
    send(32'h8000_0000, 1'b0);
    send(32'd12345, 1'b0);
    send(-32'sd9, 1'b0);
    settle();

    // binary with a zero byte and an all-ones byte as digits
    alphabet_words = '{64'h0000_0000_0000_FF00, '0, '0, '0};
    load_config(RADIX_W'(MIN_RADIX));
    send(32'hAAAA_AAAA, 1'b0);
    send(32'h5555_5555, 1'b0);
    send(32'h7FFF_FFFF, 1'b0);
    send(32'h8000_0000, 1'b0);
    send(32'd0, 1'b0);
    settle();

    shuffle_alphabet();
    load_config(RADIX_W'(MAX_RADIX_DEF));
    send(32'h8000_0000, 1'b0);
    send(32'h7FFF_FFFF, 1'b0);
    send(32'hFFFF_FFFF, 1'b0);
    settle();

    // repeated digit inside the radix
    shuffle_alphabet();
    copy_digit(3, 15);
    load_config(RADIX_W'(16));
    send(32'd255, 1'b0);
    settle();

    load_config(RADIX_W'(MIN_RADIX - 1));
    send(-32'sd5, 1'b0);
    settle();
    load_config(RADIX_W'(MAX_RADIX_DEF + 1));
    send(32'd77, 1'b0);
    settle();
    load_config(RADIX_W'(63));
    send(-32'sd77, 1'b0);
    settle();

    // repeats past the radix do not matter
    shuffle_alphabet();
    copy_digit(0, 20);
    load_config(RADIX_W'(5));
    send(-32'sd1234567, 1'b0);
    send(32'd3124, 1'b0);
    settle();

    while (item_count < ITEM_TARGET) begin
      random_setup();
      gappy = ($urandom_range(0, 3) != 0);
      n = $urandom_range(25, 45);
      repeat (n) send(pick_value(sb.radix), gappy);
      settle();
    end

    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
